// ----- rtl/ips_pkg.sv -----
// Package for the irrigation pump sequencer: beat structs, controller state codes,
// register indexes and the zone wrap table.
// Depends on nothing; used by irrigation_pump_sequencer and ips_checker.
`default_nettype none

package ips_pkg;

  localparam int EVENT_CHECK_DIVIDER_DEF = 10;
  localparam int ZONE_COUNT = 16;

  localparam int FLOW_W = 32;
  localparam int AMOUNT_W = 16;
  localparam int ZONE_W = 4;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 1;
  localparam int DIV_STEPS = FLOW_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] CFG_ERR_DETECT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_DL = 1'd1;

  localparam logic [CFG_W-1:0] ERR_DETECT_RST = 16'd10;
  localparam logic [CFG_W-1:0] TICKS_PER_DL_RST = 16'd1;

  localparam logic [2:0] MODE_IDLE = 3'd0;
  localparam logic [2:0] MODE_STARTING = 3'd1;
  localparam logic [2:0] MODE_PUMPING = 3'd2;
  localparam logic [2:0] MODE_STOPPING = 3'd3;
  localparam logic [2:0] MODE_ERROR = 3'd4;

  localparam logic [2:0] ABORT_LIMIT = 3'd3;
  localparam logic [2:0] TALLY_MAX = 3'd7;

  typedef struct packed {
    logic [FLOW_W-1:0]   flow_ticks;
    logic                event_pending;
    logic [AMOUNT_W-1:0] event_amount;
    logic [ZONE_W-1:0]   event_zone;
    logic                pump_running;
  } ips_in_t;

  typedef struct packed {
    logic              event_taken;
    logic              zone_open;
    logic [ZONE_W-1:0] zone_index;
    logic              close_all_zones;
    logic              pump_start;
    logic              pump_stop;
    logic              flow_counter_clear;
    logic              tank_use_valid;
    logic [FLOW_W-1:0] tank_use_amount;
    logic [2:0]        controller_state;
    logic [2:0]        flow_error_count;
    logic              low_flow_flag;
  } ips_out_t;

  typedef logic [(1<<ZONE_W)-1:0][ZONE_W-1:0] zone_map_t;

  // Maps each possible zone code onto the configured number of zones.
  function automatic zone_map_t zone_wrap_table();
    zone_map_t tbl;
    for (int i = 0; i < (1 << ZONE_W); i++) begin
      tbl[i] = ZONE_W'(i % ZONE_COUNT);
    end
    return tbl;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/irrigation_pump_sequencer.sv -----
// Top level of the irrigation pump sequencer: controller tick sequencing with a
// shared restoring divider for the pumped volume.
// Depends on ips_pkg.
//
//   Channel  Direction  Handshake          Payload
//   in_      input      in_valid/in_stall  ips_in_t, one controller tick
//   out_     output     out_valid/out_stall ips_out_t, one result per tick
//   cfg_     input      cfg_we             cfg_index, cfg_wdata
//
// A tick is accepted in S_IDLE. When the controller is pumping or stopping, the
// volume is then computed in S_DIV by a serial divider, one quotient bit per step.
// S_DONE finishes the tick and loads its result into the output register. The
// output register holds a stalled result while the next tick is accepted; S_DONE
// waits until that register is free. Reset is synchronous and active low; it
// restores the control and configuration registers to their defaults.
`default_nettype none

module irrigation_pump_sequencer #(
  parameter int EVENT_CHECK_DIVIDER = ips_pkg::EVENT_CHECK_DIVIDER_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  ips_pkg::ips_in_t                 in_data,
  output logic                             out_valid,
  input  wire                              out_stall,
  output ips_pkg::ips_out_t                out_data,
  input  wire                              cfg_we,
  input  wire  [ips_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [ips_pkg::CFG_W-1:0]        cfg_wdata
);
  import ips_pkg::*;

  localparam int PHASE_W = (EVENT_CHECK_DIVIDER > 1) ? $clog2(EVENT_CHECK_DIVIDER) : 1;
  localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(EVENT_CHECK_DIVIDER - 1);
  localparam zone_map_t ZONE_WRAP = zone_wrap_table();

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_DONE
  } seq_state_t;

  seq_state_t           state_r;
  ips_in_t              item_r;
  logic [CFG_W-1:0]     err_detect_r;
  logic [CFG_W-1:0]     ticks_per_dl_r;
  logic [PHASE_W-1:0]   phase_r;
  logic [2:0]           mode_r;
  logic [AMOUNT_W-1:0]  req_amount_r;
  logic [ZONE_W-1:0]    zone_r;
  logic [2:0]           tally_r;
  logic [FLOW_W-1:0]    last_flow_r;
  logic [FLOW_W-1:0]    div_q_r;
  logic [CFG_W-1:0]     div_rem_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic                 out_valid_r;
  ips_out_t             out_data_r;

  logic                 in_fire;
  logic                 need_div;
  logic [CFG_W:0]       rem_shift;
  logic [CFG_W+1:0]     rem_diff;
  logic                 rem_ge;
  logic                 out_free;

  logic [PHASE_W-1:0]   phase_nxt;
  logic [2:0]           mode_nxt;
  logic [AMOUNT_W-1:0]  req_amount_nxt;
  logic [ZONE_W-1:0]    zone_nxt;
  logic [2:0]           tally_nxt;
  logic [2:0]           tally_inc;
  logic [FLOW_W-1:0]    last_flow_nxt;
  logic [FLOW_W:0]      flow_bound;
  logic                 take;
  logic                 aborted;
  ips_out_t             res_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign need_div  = (mode_r == MODE_PUMPING) || (mode_r == MODE_STOPPING);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign rem_shift = {div_rem_r, div_q_r[FLOW_W-1]};
  assign rem_diff  = {1'b0, rem_shift} - {2'b00, ticks_per_dl_r};
  assign rem_ge    = !rem_diff[CFG_W+1];

  // Finishing step of a tick, evaluated from the held beat and the quotient.
  always_comb begin
    res_nxt        = '0;
    phase_nxt      = (phase_r == PHASE_LAST) ? '0 : phase_r + 1'b1;
    mode_nxt       = mode_r;
    req_amount_nxt = req_amount_r;
    zone_nxt       = zone_r;
    tally_nxt      = tally_r;
    last_flow_nxt  = last_flow_r;
    aborted        = 1'b0;
    tally_inc      = (tally_r != TALLY_MAX) ? tally_r + 3'd1 : tally_r;
    flow_bound     = {1'b0, last_flow_r} + {{(FLOW_W + 1 - CFG_W){1'b0}}, err_detect_r};
    take           = (phase_r == '0) && (mode_r == MODE_IDLE) &&
                     item_r.event_pending && !item_r.pump_running;

    if (take) begin
      res_nxt.event_taken = 1'b1;
      req_amount_nxt      = item_r.event_amount;
      zone_nxt            = ZONE_WRAP[item_r.event_zone];
      mode_nxt            = MODE_STARTING;
    end

    unique case (mode_nxt)
      MODE_STARTING: begin
        res_nxt.zone_open          = 1'b1;
        res_nxt.flow_counter_clear = 1'b1;
        res_nxt.pump_start         = 1'b1;
        tally_nxt                  = '0;
        last_flow_nxt              = '0;
        mode_nxt                   = MODE_PUMPING;
      end
      MODE_PUMPING: begin
        if (flow_bound >= {1'b0, item_r.flow_ticks}) begin
          res_nxt.low_flow_flag = 1'b1;
          tally_nxt             = tally_inc;
          if (tally_inc > ABORT_LIMIT) begin
            res_nxt.pump_stop       = 1'b1;
            res_nxt.close_all_zones = 1'b1;
            res_nxt.tank_use_valid  = 1'b1;
            res_nxt.tank_use_amount = div_q_r;
            mode_nxt                = MODE_ERROR;
            aborted                 = 1'b1;
          end
        end
        if (!aborted) begin
          last_flow_nxt = item_r.flow_ticks;
          if (div_q_r >= {{(FLOW_W - AMOUNT_W){1'b0}}, req_amount_r}) begin
            mode_nxt = MODE_STOPPING;
          end
        end
      end
      MODE_STOPPING: begin
        res_nxt.pump_stop       = 1'b1;
        res_nxt.close_all_zones = 1'b1;
        res_nxt.tank_use_valid  = 1'b1;
        res_nxt.tank_use_amount = div_q_r;
        mode_nxt                = MODE_IDLE;
      end
      default: begin
      end
    endcase

    res_nxt.zone_index       = zone_nxt;
    res_nxt.controller_state = mode_nxt;
    res_nxt.flow_error_count = tally_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      err_detect_r   <= ERR_DETECT_RST;
      ticks_per_dl_r <= TICKS_PER_DL_RST;
      phase_r        <= '0;
      mode_r         <= MODE_IDLE;
      req_amount_r   <= '0;
      zone_r         <= '0;
      tally_r        <= '0;
      last_flow_r    <= '0;
      div_cnt_r      <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ERR_DETECT:   err_detect_r   <= cfg_wdata;
          CFG_TICKS_PER_DL: ticks_per_dl_r <= cfg_wdata;
          default: begin
          end
        endcase
      end

      if (out_valid_r && !out_stall && !((state_r == S_DONE) && out_free)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            item_r    <= in_data;
            div_q_r   <= in_data.flow_ticks;
            div_rem_r <= '0;
            div_cnt_r <= '0;
            state_r   <= need_div ? S_DIV : S_DONE;
          end
        end
        S_DIV: begin
          div_rem_r <= rem_ge ? rem_diff[CFG_W-1:0] : rem_shift[CFG_W-1:0];
          div_q_r   <= {div_q_r[FLOW_W-2:0], rem_ge};
          div_cnt_r <= div_cnt_r + 1'b1;
          if (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            phase_r      <= phase_nxt;
            mode_r       <= mode_nxt;
            req_amount_r <= req_amount_nxt;
            zone_r       <= zone_nxt;
            tally_r      <= tally_nxt;
            last_flow_r  <= last_flow_nxt;
            out_data_r   <= res_nxt;
            out_valid_r  <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ips_checker.sv -----
// Port-level checker for the irrigation pump sequencer, bound to the top level.
// Depends on ips_pkg and irrigation_pump_sequencer.
`default_nettype none

module ips_port_assertions (
  input wire                clk,
  input wire                rst_n,
  input wire                out_valid,
  input wire                out_stall,
  input ips_pkg::ips_out_t  out_data
);
  import ips_pkg::*;

  logic err_seen_r;

  // Remembers that an error result has been delivered; the error state is terminal.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_seen_r <= 1'b0;
    end else if (out_valid && !out_stall && (out_data.controller_state == MODE_ERROR)) begin
      err_seen_r <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  a_start_pulses: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.pump_start |->
      out_data.event_taken && out_data.zone_open && out_data.flow_counter_clear &&
      (out_data.controller_state == MODE_PUMPING))
    else $error("pump start without event take, zone open and counter clear");

  a_use_with_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.tank_use_valid |->
      out_data.pump_stop && out_data.close_all_zones && !out_data.pump_start)
    else $error("tank use reported without pump stop and zone close");

  a_error_terminal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && err_seen_r |->
      (out_data.controller_state == MODE_ERROR) && !out_data.event_taken)
    else $error("controller left the error state");

  a_tally_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.flow_error_count > (ABORT_LIMIT + 3'd1)) |-> 1'b0)
    else $error("low-flow count beyond the abort limit");

endmodule

bind irrigation_pump_sequencer ips_port_assertions u_ips_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
